// File: design/srr_pkg.sv
// shared types and constants for the selective repeat receiver
package srr_pkg;

  // packet types carried in the header
  localparam logic [3:0] PKT_START = 4'd0;
  localparam logic [3:0] PKT_END   = 4'd1;
  localparam logic [3:0] PKT_DATA  = 4'd2;
  localparam logic [3:0] PKT_ACK   = 4'd3;

  // result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // sizing: 1500 byte frame minus ip, udp and packet headers
  localparam int WINDOW_MAX     = 32;
  localparam int MAX_DATA_BYTES = 1500 - 20 - 8 - 16;
  localparam int SLOT_W         = $clog2(WINDOW_MAX);
  localparam int STEP_W         = $clog2(WINDOW_MAX + 1);
  localparam int WIN_W          = 6;

  typedef struct packed {
    logic [3:0]  pkt_type;
    logic [31:0] seq_num;
    logic [10:0] payload_length;
    logic        length_matches;
    logic        crc_ok;
    logic [47:0] peer_id;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [31:0] out_seq;
    logic [15:0] file_number;
    logic        last;
  } out_item_t;

  // what the datapath decided for the captured packet
  typedef enum logic [2:0] {
    DEC_DROP,
    DEC_OPEN,
    DEC_ACK,
    DEC_CLOSE,
    DEC_MARK,
    DEC_DELIVER
  } dec_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic open;
    logic close;
    logic mark;
    logic first;
    logic drain;
    logic ack;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    dec_t dec;
    logic drain_more;
    logic out_free;
  } ctrl_stat_t;

endpackage

// File: design/srr_ctrl.sv
// controller state machine for the selective repeat receiver
module srr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  srr_pkg::ctrl_stat_t stat,
  output srr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_ACK   = 4'b1000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        case (stat.dec)
          srr_pkg::DEC_DROP: begin
            state_next = S_IDLE;
          end
          srr_pkg::DEC_DELIVER: begin
            if (stat.out_free) begin
              cmd.first  = 1'b1;
              state_next = S_DRAIN;
            end
          end
          srr_pkg::DEC_OPEN, srr_pkg::DEC_ACK, srr_pkg::DEC_CLOSE,
          srr_pkg::DEC_MARK: begin
            if (stat.out_free) begin
              cmd.ack    = 1'b1;
              cmd.open   = (stat.dec == srr_pkg::DEC_OPEN);
              cmd.close  = (stat.dec == srr_pkg::DEC_CLOSE);
              cmd.mark   = (stat.dec == srr_pkg::DEC_MARK);
              state_next = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DRAIN: begin
        // release buffered slots one per cycle while the result register is free
        if (!stat.drain_more) begin
          state_next = S_ACK;
        end else if (stat.out_free) begin
          cmd.drain = 1'b1;
        end
      end
      S_ACK: begin
        if (stat.out_free) begin
          cmd.ack    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/srr_datapath.sv
// connection state, slot bitmap, packet classification and result register
module srr_datapath (
  input  logic                clk,
  input  logic                rst,
  input  srr_pkg::in_item_t   in_item,
  input  logic                cfg_valid,
  input  logic [srr_pkg::WIN_W-1:0] cfg_data,
  input  srr_pkg::ctrl_cmd_t  cmd,
  output srr_pkg::ctrl_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output srr_pkg::out_item_t  out_item
);

  srr_pkg::in_item_t cap;
  logic [srr_pkg::WIN_W-1:0]  window_size;
  logic                       connected;
  logic [47:0]                active_peer;
  logic [31:0]                opening_seq;
  logic [31:0]                expected_seq;
  logic [srr_pkg::WINDOW_MAX-1:0] slot_held;
  logic [15:0]                connection_count;
  logic [srr_pkg::STEP_W-1:0] step;

  logic [srr_pkg::WIN_W-1:0]  win;
  logic [32:0]                win_limit;
  logic                       malformed;
  srr_pkg::dec_t              dec;
  logic                       load;

  // captured packet
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap <= in_item;
    end
  end

  // window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= srr_pkg::WIN_W'(1);
    end else if (cfg_valid) begin
      window_size <= cfg_data;
    end
  end

  // window saturated to the bitmap depth, compared on 33 bits
  assign win = (window_size > srr_pkg::WIN_W'(srr_pkg::WINDOW_MAX)) ?
               srr_pkg::WIN_W'(srr_pkg::WINDOW_MAX) : window_size;
  assign win_limit = {1'b0, expected_seq} + 33'(win);

  // header checks
  always_comb begin
    malformed = (cap.pkt_type > srr_pkg::PKT_ACK) || !cap.length_matches ||
                (cap.payload_length > 11'(srr_pkg::MAX_DATA_BYTES));
    if (cap.pkt_type == srr_pkg::PKT_DATA) begin
      if (!cap.crc_ok) malformed = 1'b1;
    end else if (cap.payload_length != 11'd0) begin
      malformed = 1'b1;
    end
  end

  // classification
  always_comb begin
    dec = srr_pkg::DEC_DROP;
    if (malformed) begin
      dec = srr_pkg::DEC_DROP;
    end else if (!connected) begin
      if (cap.pkt_type == srr_pkg::PKT_START) dec = srr_pkg::DEC_OPEN;
    end else if (cap.peer_id == active_peer) begin
      case (cap.pkt_type)
        srr_pkg::PKT_START: begin
          if (cap.seq_num == opening_seq) dec = srr_pkg::DEC_ACK;
        end
        srr_pkg::PKT_END: begin
          dec = srr_pkg::DEC_CLOSE;
        end
        srr_pkg::PKT_DATA: begin
          if ({1'b0, cap.seq_num} >= win_limit) begin
            dec = srr_pkg::DEC_DROP;
          end else if (cap.seq_num < expected_seq) begin
            dec = srr_pkg::DEC_ACK;
          end else if (cap.seq_num == expected_seq) begin
            dec = srr_pkg::DEC_DELIVER;
          end else begin
            dec = srr_pkg::DEC_MARK;
          end
        end
        default: begin
          dec = srr_pkg::DEC_DROP;
        end
      endcase
    end
  end

  assign stat.dec        = dec;
  assign stat.drain_more = slot_held[expected_seq[srr_pkg::SLOT_W-1:0]] &&
                           (step < srr_pkg::STEP_W'(srr_pkg::WINDOW_MAX));
  assign stat.out_free   = !out_valid || !out_stall;

  // connection state and bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      connected        <= 1'b0;
      active_peer      <= '0;
      opening_seq      <= '0;
      expected_seq     <= '0;
      slot_held        <= '0;
      connection_count <= '0;
      step             <= '0;
    end else begin
      if (cmd.open) begin
        connected    <= 1'b1;
        active_peer  <= cap.peer_id;
        opening_seq  <= cap.seq_num;
        expected_seq <= '0;
        slot_held    <= '0;
      end
      if (cmd.close) begin
        connected        <= 1'b0;
        opening_seq      <= '0;
        expected_seq     <= '0;
        slot_held        <= '0;
        connection_count <= connection_count + 16'd1;
      end
      if (cmd.mark) begin
        slot_held[cap.seq_num[srr_pkg::SLOT_W-1:0]] <= 1'b1;
      end
      if (cmd.first) begin
        expected_seq <= expected_seq + 32'd1;
        step         <= '0;
      end
      if (cmd.drain) begin
        slot_held[expected_seq[srr_pkg::SLOT_W-1:0]] <= 1'b0;
        expected_seq <= expected_seq + 32'd1;
        step         <= step + srr_pkg::STEP_W'(1);
      end
    end
  end

  // result register
  assign load = cmd.ack || cmd.first || cmd.drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.file_number <= connection_count;
      if (cmd.first) begin
        out_item.out_kind <= srr_pkg::KIND_DELIVER;
        out_item.out_seq  <= cap.seq_num;
        out_item.last     <= 1'b0;
      end else if (cmd.drain) begin
        out_item.out_kind <= srr_pkg::KIND_DELIVER;
        out_item.out_seq  <= expected_seq;
        out_item.last     <= 1'b0;
      end else begin
        out_item.out_kind <= srr_pkg::KIND_ACK;
        out_item.out_seq  <= cap.seq_num;
        out_item.last     <= 1'b1;
      end
    end
  end

endmodule

// File: design/selective_repeat_receiver_core.sv
// top level of the selective repeat receiver: controller plus datapath
// One packet header is taken per item while in_stall is low; the block then
// holds in_stall high until that packet is done. A dropped packet ends with
// its evaluation, a packet answered by a single acknowledgement ends when the
// acknowledgement is loaded, and an in-order data packet that releases k
// buffered slots goes through the first delivery, one release per slot in the
// drain loop, the loop exit and the acknowledgement; each result waits while
// the result register is held by out_stall. Results come from a single output
// register, one per cycle in the drain loop while out_stall is low, and the
// next packet is taken while the last result of the previous one still waits
// there. The window register (6 bits, reset 1, saturated to 32) may be
// written at any time the block is idle; cfg_ready is always high.
module selective_repeat_receiver_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  srr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output srr_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [srr_pkg::WIN_W-1:0] cfg_data
);

  srr_pkg::ctrl_cmd_t  cmd;
  srr_pkg::ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencing
  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state and results
  srr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: design/srr_checker.sv
// port level checks for the selective repeat receiver, bound to the top level
module srr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input srr_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a taken item makes the block busy in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // while a non-final result waits, the packet is still in progress
  a_busy_mid_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> in_stall)
    else $error("input open before the final result of a packet");

  // acknowledgements always close a packet's results
  a_ack_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.out_kind == srr_pkg::KIND_ACK) |-> out_item.last)
    else $error("acknowledgement not marked last");

endmodule

bind selective_repeat_receiver_core srr_checker u_srr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
